// ===== sv/sqmf_pkg.sv =====
// Shared types and constants for the shortest-queue multi-FIFO block.
// No dependencies; used by the channel interfaces and the top level.
package sqmf_pkg;

  localparam int FUNC_W   = 1;
  localparam int QIDX_W   = 4;
  localparam int MSG_W    = 32;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  localparam logic [FUNC_W-1:0] FUNC_PUT = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_GET = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ===== sv/sqmf_in_if.sv =====
// Input channel: valid/ready handshake carrying one put or get request.
// Depends on sqmf_pkg for field widths.
interface sqmf_in_if;
  logic                         valid;
  logic                         ready;
  logic [sqmf_pkg::FUNC_W-1:0]  func;
  logic [sqmf_pkg::QIDX_W-1:0]  queue_index;
  logic [sqmf_pkg::MSG_W-1:0]   message;

  modport source (output valid, func, queue_index, message, input ready);
  modport sink   (input valid, func, queue_index, message, output ready);
endinterface

// ===== sv/sqmf_out_if.sv =====
// Result channel: valid/ready handshake carrying one result per request.
// Depends on sqmf_pkg for field widths and the status type.
interface sqmf_out_if;
  logic                         valid;
  logic                         ready;
  logic [sqmf_pkg::DATA_W-1:0]  data;
  sqmf_pkg::status_t            status;
  logic [sqmf_pkg::QIDX_W-1:0]  chosen_queue;
  logic [sqmf_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, data, status, chosen_queue, occupancy, input ready);
  modport sink   (input valid, data, status, chosen_queue, occupancy, output ready);
endinterface

// ===== sv/sqmf_cfg_if.sv =====
// Configuration write channel: valid/ready handshake carrying the queue limit.
// Depends on sqmf_pkg for the register width.
interface sqmf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sqmf_pkg::LIMIT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/shortest_queue_multi_fifo.sv =====
// Join-shortest-queue dispatcher over a bank of bounded FIFOs.
// Depends on sqmf_pkg, sqmf_in_if, sqmf_out_if and sqmf_cfg_if.
//
// Usage:
//   in_if   : one transaction per request. func = put pushes message into the
//             least occupied queue (ties to the lowest index); func = get pops
//             the head of queue_index. Neither operation blocks: a put with
//             every queue at the limit returns status FULL, a get on an empty
//             (or nonexistent) queue returns status EMPTY.
//   out_if  : exactly one result transaction per request, in request order.
//   cfg_if  : writes queue_limit (always ready). Write only while idle.
// Timing:
//   One request in flight; in_if.ready is high only when idle. A put scans the
//   per-queue state memory one entry per cycle (single read port), then writes
//   the chosen queue and registers its result; no new request is taken until
//   that result is loaded. A get reads the state memory, then the message
//   memory (skipped when the queue is empty), and registers its result.
//   While the receiver stalls, the next request runs up to its result and waits.
// Reset:
//   rst_n (synchronous) empties every queue by clearing the per-entry valid
//   bits of the state memory and sets queue_limit to 10. No clearing pass.
module shortest_queue_multi_fifo #(
  parameter int NUM_QUEUES  = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  sqmf_in_if.sink     in_if,
  sqmf_out_if.source  out_if,
  sqmf_cfg_if.sink    cfg_if
);

  localparam int QW    = $clog2(NUM_QUEUES);        // queue index
  localparam int HW    = $clog2(QUEUE_DEPTH);       // slot / head pointer
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);   // occupancy count
  localparam int SUMW  = CW + 1;
  localparam int EW    = HW + CW;                   // state entry {head, count}
  localparam int SCW   = QW + 1;                    // scan issue counter
  localparam int MSD   = NUM_QUEUES * QUEUE_DEPTH;
  localparam int MAW   = $clog2(MSD);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PUT,
    S_GET_Q,
    S_GET_D,
    S_FIN
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [sqmf_pkg::LIMIT_W-1:0] limit_r;
  logic [CW-1:0]                lim_eff;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sqmf_pkg::LIMIT_RESET;
    end else if (cfg_if.valid) begin
      limit_r <= cfg_if.data;
    end
  end

  // limit above the physical depth clamps to the depth
  assign lim_eff = (32'(limit_r) > 32'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(limit_r);

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  state_t                        state_r;
  logic [sqmf_pkg::QIDX_W-1:0]   item_qidx_r;
  logic [DATA_WIDTH-1:0]         item_msg_r;

  logic [SCW-1:0]                scan_issue_r;
  logic [QW-1:0]                 rd_idx_r;
  logic                          found_r;
  logic [QW-1:0]                 best_idx_r;
  logic [CW-1:0]                 best_cnt_r;
  logic [HW-1:0]                 best_head_r;

  logic [sqmf_pkg::DATA_W-1:0]   res_data_r;
  sqmf_pkg::status_t             res_status_r;
  logic [sqmf_pkg::QIDX_W-1:0]   res_queue_r;
  logic [sqmf_pkg::OCC_W-1:0]    res_occ_r;

  logic                          out_valid_r;
  logic [sqmf_pkg::DATA_W-1:0]   out_data_r;
  sqmf_pkg::status_t             out_status_r;
  logic [sqmf_pkg::QIDX_W-1:0]   out_queue_r;
  logic [sqmf_pkg::OCC_W-1:0]    out_occ_r;

  // ---------------------------------------------------------------------------
  // Per-queue state memory {head, count}, valid bit per entry for reset
  // ---------------------------------------------------------------------------
  logic [EW-1:0]          qs_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0]  qs_valid_r;
  logic [EW-1:0]          qs_rdata_r;
  logic                   qs_rvld_r;
  logic [QW-1:0]          qs_raddr;
  logic                   qs_we;
  logic [QW-1:0]          qs_waddr;
  logic [EW-1:0]          qs_wdata;

  // Message memory
  logic [DATA_WIDTH-1:0]  ms_mem [MSD];
  logic [DATA_WIDTH-1:0]  ms_rdata_r;
  logic [MAW-1:0]         ms_raddr;
  logic                   ms_we;
  logic [MAW-1:0]         ms_waddr;

  always_ff @(posedge clk) begin
    if (qs_we) begin
      qs_mem[qs_waddr] <= qs_wdata;
    end
    qs_rdata_r <= qs_mem[qs_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs_valid_r <= '0;
      qs_rvld_r  <= 1'b0;
    end else begin
      if (qs_we) begin
        qs_valid_r[qs_waddr] <= 1'b1;
      end
      qs_rvld_r <= qs_valid_r[qs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ms_we) begin
      ms_mem[ms_waddr] <= item_msg_r;
    end
    ms_rdata_r <= ms_mem[ms_raddr];
  end

  // entry returned by last cycle's read; an unwritten entry is an empty queue
  logic [CW-1:0] ent_cnt;
  logic [HW-1:0] ent_head;
  logic [HW-1:0] head_inc;
  logic          get_in_range;
  logic [QW-1:0] get_q;
  logic          better;
  logic [SUMW-1:0] tail_sum;
  logic [HW-1:0]   tail;

  assign ent_cnt  = qs_rvld_r ? qs_rdata_r[CW-1:0]    : '0;
  assign ent_head = qs_rvld_r ? qs_rdata_r[EW-1:CW]   : '0;
  assign head_inc = (ent_head == HW'(QUEUE_DEPTH - 1)) ? '0 : ent_head + 1'b1;

  assign get_in_range = (32'(item_qidx_r) < 32'(NUM_QUEUES));
  assign get_q        = QW'(item_qidx_r);

  assign better = (ent_cnt < lim_eff) && (!found_r || (ent_cnt < best_cnt_r));

  assign tail_sum = SUMW'(best_head_r) + SUMW'(best_cnt_r);
  assign tail     = (tail_sum >= SUMW'(QUEUE_DEPTH)) ? HW'(tail_sum - SUMW'(QUEUE_DEPTH))
                                                     : HW'(tail_sum);

  // memory port control
  always_comb begin
    qs_raddr = '0;
    qs_we    = 1'b0;
    qs_waddr = best_idx_r;
    qs_wdata = {best_head_r, CW'(best_cnt_r + 1'b1)};
    ms_raddr = MAW'(get_q) * MAW'(QUEUE_DEPTH) + MAW'(ent_head);
    ms_we    = 1'b0;
    ms_waddr = MAW'(best_idx_r) * MAW'(QUEUE_DEPTH) + MAW'(tail);
    case (state_r)
      S_IDLE: begin
        if (in_if.func == sqmf_pkg::FUNC_GET) begin
          qs_raddr = QW'(in_if.queue_index);
        end
      end
      S_SCAN: begin
        qs_raddr = QW'(scan_issue_r);
      end
      S_PUT: begin
        qs_we = found_r;
        ms_we = found_r;
      end
      S_GET_Q: begin
        if (get_in_range && (ent_cnt != '0)) begin
          qs_we    = 1'b1;
          qs_waddr = get_q;
          qs_wdata = {head_inc, CW'(ent_cnt - 1'b1)};
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer and registered outputs
  // ---------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid_r && out_if.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      rd_idx_r <= qs_raddr;
      case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            item_qidx_r  <= in_if.queue_index;
            item_msg_r   <= DATA_WIDTH'(in_if.message);
            found_r      <= 1'b0;
            scan_issue_r <= SCW'(1);
            if (in_if.func == sqmf_pkg::FUNC_GET) begin
              state_r <= S_GET_Q;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // one entry returns per cycle; keep the running minimum
          if (better) begin
            found_r     <= 1'b1;
            best_idx_r  <= rd_idx_r;
            best_cnt_r  <= ent_cnt;
            best_head_r <= ent_head;
          end
          scan_issue_r <= scan_issue_r + 1'b1;
          if (rd_idx_r == QW'(NUM_QUEUES - 1)) begin
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          res_data_r <= '0;
          if (found_r) begin
            res_status_r <= sqmf_pkg::ST_OK;
            res_queue_r  <= sqmf_pkg::QIDX_W'(best_idx_r);
            res_occ_r    <= sqmf_pkg::OCC_W'(best_cnt_r + 1'b1);
          end else begin
            res_status_r <= sqmf_pkg::ST_FULL;
            res_queue_r  <= '0;
            res_occ_r    <= '0;
          end
          state_r <= S_FIN;
        end
        S_GET_Q: begin
          res_data_r  <= '0;
          res_queue_r <= item_qidx_r;
          if (get_in_range && (ent_cnt != '0)) begin
            res_status_r <= sqmf_pkg::ST_OK;
            res_occ_r    <= sqmf_pkg::OCC_W'(ent_cnt - 1'b1);
            state_r      <= S_GET_D;
          end else begin
            res_status_r <= sqmf_pkg::ST_EMPTY;
            res_occ_r    <= '0;
            state_r      <= S_FIN;
          end
        end
        S_GET_D: begin
          res_data_r <= sqmf_pkg::DATA_W'(ms_rdata_r);
          state_r    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= res_data_r;
            out_status_r <= res_status_r;
            out_queue_r  <= res_queue_r;
            out_occ_r    <= res_occ_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready         = (state_r == S_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.data         = out_data_r;
  assign out_if.status       = out_status_r;
  assign out_if.chosen_queue = out_queue_r;
  assign out_if.occupancy    = out_occ_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // one request in flight: an accepted transaction drops ready next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request accepted while another is in flight");

  // a push never takes a queue past the effective limit
  a_put_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT && qs_we) |-> (CW'(best_cnt_r + 1'b1) <= lim_eff))
    else $error("push exceeds queue limit");

  // a pop writes back only a nonempty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GET_Q && qs_we) |-> (ent_cnt != '0))
    else $error("pop from empty queue");

  // results enter the output register only from the finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside finish step");

  // the scan ends exactly after the last queue entry returned
  a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |-> $past(state_r == S_SCAN && rd_idx_r == QW'(NUM_QUEUES - 1)))
    else $error("queue scan ended early");

endmodule
